/* hw/rtl/stlc_pkg.sv */
// Shared types and constants for the session ticket cache.
package stlc_pkg;

  localparam int CFG_W = 5;

  typedef enum logic [1:0] {
    KIND_STORE = 2'd0,
    KIND_TAKE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_MAX_ENTRIES    = 2'd0,
    REG_MAX_PER_ORIGIN = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRUNE,
    ST_DROP,
    ST_APPEND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] host;
    logic [15:0] port;
    logic [7:0]  proxy;
    logic [63:0] expiry;
    logic [31:0] ticket;
  } entry_t;

endpackage

/* hw/rtl/session_ticket_lru_cache_unit.sv */
// Session ticket cache top level: entry RAM, compaction walker and counters.
//
// Holds up to DEPTH resume tickets in one RAM, compacted oldest first. An item
// is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle with done high, and the receiver cannot stall it.
// Clear, and store/take when a limit is zero or the ticket is already stale,
// go straight to the finish state. Other items walk the RAM: one prune pass
// (one entry read per cycle through the single read port, expired entries
// dropped and the survivors written back in place), then for a take hit or a
// store that must evict a second pass that removes the chosen entries, and for
// a store an append of the new entry. Configuration writes are always ready and
// must only arrive while the block is idle.
module session_ticket_lru_cache_unit
  import stlc_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] host_key,
  input  logic [15:0] port,
  input  logic [7:0]  proxy_id,
  input  logic [63:0] now,
  input  logic [63:0] expiry,
  input  logic [31:0] ticket,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic        hit,
  output logic [31:0] ticket_out,
  output logic [4:0]  entry_count,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] stored_total,
  output logic [31:0] evicted_total,
  output logic [31:0] expired_total,
  output logic [4:0]  cleared_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  // Configuration; always accept, transfer completes on valid
  logic [CFG_W-1:0] max_entries;
  logic [CFG_W-1:0] max_per_origin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries    <= CFG_W'(16);
      max_per_origin <= CFG_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_ENTRIES:    max_entries    <= cfg_data;
        REG_MAX_PER_ORIGIN: max_per_origin <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control and walk registers
  state_t        state, state_next;
  kind_t         op, op_next;
  entry_t        item, item_next;
  logic [63:0]   cur_now, cur_now_next;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] rd_ptr, rd_ptr_next;
  logic          rdv, rdv_next;
  logic [CW-1:0] wr_ptr, wr_ptr_next;
  logic [CW-1:0] pidx, pidx_next;
  logic [CW-1:0] route_n, route_n_next;
  logic [CW-1:0] first_idx, first_idx_next;
  logic [CW-1:0] last_idx, last_idx_next;
  logic [CW-1:0] drop_idx, drop_idx_next;
  logic          drop_en, drop_en_next;
  logic [CW-1:0] skip_k, skip_k_next;
  logic [CW-1:0] skipped, skipped_next;
  logic [31:0]   hits_cnt, hits_cnt_next;
  logic [31:0]   miss_cnt, miss_cnt_next;
  logic [31:0]   stored_cnt, stored_cnt_next;
  logic [31:0]   evict_cnt, evict_cnt_next;
  logic [31:0]   expire_cnt, expire_cnt_next;
  logic          hit_r, hit_r_next;
  logic [31:0]   tout, tout_next;
  logic [CW-1:0] cleared, cleared_next;
  logic          done_next;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  stlc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held       <= '0;
      rdv        <= 1'b0;
      done       <= 1'b0;
      hits_cnt   <= '0;
      miss_cnt   <= '0;
      stored_cnt <= '0;
      evict_cnt  <= '0;
      expire_cnt <= '0;
      hit_r      <= 1'b0;
      tout       <= '0;
      cleared    <= '0;
    end else begin
      state      <= state_next;
      held       <= held_next;
      rdv        <= rdv_next;
      done       <= done_next;
      hits_cnt   <= hits_cnt_next;
      miss_cnt   <= miss_cnt_next;
      stored_cnt <= stored_cnt_next;
      evict_cnt  <= evict_cnt_next;
      expire_cnt <= expire_cnt_next;
      hit_r      <= hit_r_next;
      tout       <= tout_next;
      cleared    <= cleared_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    item      <= item_next;
    cur_now   <= cur_now_next;
    rd_ptr    <= rd_ptr_next;
    wr_ptr    <= wr_ptr_next;
    pidx      <= pidx_next;
    route_n   <= route_n_next;
    first_idx <= first_idx_next;
    last_idx  <= last_idx_next;
    drop_idx  <= drop_idx_next;
    drop_en   <= drop_en_next;
    skip_k    <= skip_k_next;
    skipped   <= skipped_next;
  end

  // Walker helpers
  logic          rd_go;
  logic          pass_end;
  logic          stale;
  logic          match;
  logic          enabled;
  logic          go;
  logic          drop_route;
  logic [LW-1:0] n1_e;
  logic [LW-1:0] lim_e;
  logic [LW-1:0] k_e;

  assign rd_go     = (rd_ptr < held);
  assign pass_end  = !rd_go && !rdv;
  assign ram_raddr = rd_ptr[AW-1:0];
  assign stale     = !(cur_now < ram_rdata.expiry);
  assign match     = (ram_rdata.host == item.host) && (ram_rdata.port == item.port) &&
                     (ram_rdata.proxy == item.proxy);
  assign enabled   = (max_entries != '0) && (max_per_origin != '0);

  always_comb begin
    go = 1'b0;
    case (kind_t'(kind))
      KIND_STORE: go = enabled && (now < expiry);
      KIND_TAKE:  go = enabled;
      KIND_QUERY: go = 1'b1;
      default:    go = 1'b0;
    endcase
  end

  // Eviction plan for a store, from the prune pass result
  always_comb begin
    drop_route = (route_n != '0) && (LW'(route_n) >= LW'(max_per_origin));
    n1_e       = LW'(wr_ptr) - LW'(drop_route);
    lim_e      = (LW'(max_entries) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(max_entries);
    k_e        = (n1_e >= lim_e) ? (n1_e - lim_e + LW'(1)) : '0;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    item_next       = item;
    cur_now_next    = cur_now;
    held_next       = held;
    rd_ptr_next     = rd_ptr;
    rdv_next        = 1'b0;
    wr_ptr_next     = wr_ptr;
    pidx_next       = pidx;
    route_n_next    = route_n;
    first_idx_next  = first_idx;
    last_idx_next   = last_idx;
    drop_idx_next   = drop_idx;
    drop_en_next    = drop_en;
    skip_k_next     = skip_k;
    skipped_next    = skipped;
    hits_cnt_next   = hits_cnt;
    miss_cnt_next   = miss_cnt;
    stored_cnt_next = stored_cnt;
    evict_cnt_next  = evict_cnt;
    expire_cnt_next = expire_cnt;
    hit_r_next      = hit_r;
    tout_next       = tout;
    cleared_next    = cleared;
    done_next       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = wr_ptr[AW-1:0];
    ram_wdata       = ram_rdata;

    case (state)
      ST_IDLE: begin
        if (start) begin
          op_next        = kind_t'(kind);
          item_next      = '{host: host_key, port: port, proxy: proxy_id,
                             expiry: expiry, ticket: ticket};
          cur_now_next   = now;
          rd_ptr_next    = '0;
          wr_ptr_next    = '0;
          route_n_next   = '0;
          first_idx_next = '0;
          last_idx_next  = '0;
          hit_r_next     = 1'b0;
          tout_next      = '0;
          cleared_next   = '0;
          state_next     = go ? ST_PRUNE : ST_FINISH;
        end
      end

      ST_PRUNE: begin
        // Stream entries out, drop expired ones, write survivors back compacted
        if (rd_go) begin
          rd_ptr_next = rd_ptr + CW'(1);
          rdv_next    = 1'b1;
        end
        if (rdv) begin
          if (stale) begin
            expire_cnt_next = expire_cnt + 32'd1;
          end else begin
            ram_we      = 1'b1;
            wr_ptr_next = wr_ptr + CW'(1);
            if (match) begin
              if (route_n == '0) begin
                first_idx_next = wr_ptr;
              end
              last_idx_next = wr_ptr;
              route_n_next  = route_n + CW'(1);
            end
          end
        end
        if (pass_end) begin
          held_next    = wr_ptr;
          rd_ptr_next  = '0;
          wr_ptr_next  = '0;
          pidx_next    = '0;
          skipped_next = '0;
          case (op)
            KIND_TAKE: begin
              drop_en_next  = 1'b1;
              drop_idx_next = last_idx;
              skip_k_next   = '0;
              if (route_n == '0) begin
                miss_cnt_next = miss_cnt + 32'd1;
                state_next    = ST_FINISH;
              end else begin
                state_next = ST_DROP;
              end
            end
            KIND_STORE: begin
              drop_en_next   = drop_route;
              drop_idx_next  = first_idx;
              skip_k_next    = CW'(k_e);
              evict_cnt_next = evict_cnt + 32'(drop_route) + 32'(k_e);
              state_next     = (drop_route || (k_e != '0)) ? ST_DROP : ST_APPEND;
            end
            default: state_next = ST_FINISH;
          endcase
        end
      end

      ST_DROP: begin
        // Remove the chosen route entry and the k oldest others
        if (rd_go) begin
          rd_ptr_next = rd_ptr + CW'(1);
          rdv_next    = 1'b1;
        end
        if (rdv) begin
          pidx_next = pidx + CW'(1);
          if (drop_en && (pidx == drop_idx)) begin
            hit_r_next = (op == KIND_TAKE);
            tout_next  = (op == KIND_TAKE) ? ram_rdata.ticket : tout;
          end else if (skipped < skip_k) begin
            skipped_next = skipped + CW'(1);
          end else begin
            ram_we      = 1'b1;
            wr_ptr_next = wr_ptr + CW'(1);
          end
        end
        if (pass_end) begin
          held_next = wr_ptr;
          if (op == KIND_TAKE) begin
            hits_cnt_next = hits_cnt + 32'd1;
            state_next    = ST_FINISH;
          end else begin
            state_next = ST_APPEND;
          end
        end
      end

      ST_APPEND: begin
        ram_we          = 1'b1;
        ram_waddr       = held[AW-1:0];
        ram_wdata       = item;
        held_next       = held + CW'(1);
        stored_cnt_next = stored_cnt + 32'd1;
        state_next      = ST_FINISH;
      end

      ST_FINISH: begin
        if (op == KIND_CLEAR) begin
          cleared_next = held;
          held_next    = '0;
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign busy          = (state != ST_IDLE);
  assign hit           = hit_r;
  assign ticket_out    = tout;
  assign entry_count   = CFG_W'(held);
  assign hit_total     = hits_cnt;
  assign miss_total    = miss_cnt;
  assign stored_total  = stored_cnt;
  assign evicted_total = evict_cnt;
  assign expired_total = expire_cnt;
  assign cleared_count = CFG_W'(cleared);

endmodule

/* hw/rtl/stlc_ram.sv */
// Generic simple dual-port RAM with registered read data.
module stlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
